/* rtl/core/tbsd_pkg.sv */
// Package for the tagged byte stream decoder: tag register indexes, result kinds,
// parser states and the result record. No dependencies.
package tbsd_pkg;

    localparam int NumTags   = 8;
    localparam int TagIdxW   = $clog2(NumTags);
    localparam int ByteW     = 8;
    localparam int KindW     = 4;
    localparam int ValueW    = 64;
    localparam int IndexW    = 32;
    localparam int CountW    = 3;

    typedef logic [NumTags-1:0][ByteW-1:0] tag_array_t;

    typedef enum logic [TagIdxW-1:0] {
        TAG_INT        = 3'd0,
        TAG_FLOAT      = 3'd1,
        TAG_SYMBOL_REF = 3'd2,
        TAG_SYMBOL_DEF = 3'd3,
        TAG_STRING     = 3'd4,
        TAG_RAW_STRING = 3'd5,
        TAG_OBJECT     = 3'd6,
        TAG_END        = 3'd7
    } tag_sel_t;

    typedef enum logic [KindW-1:0] {
        KIND_INT    = 4'd0,
        KIND_FLOAT  = 4'd1,
        KIND_SYMREF = 4'd2,
        KIND_SYMDEF = 4'd3,
        KIND_STRING = 4'd4,
        KIND_RAW    = 4'd5,
        KIND_OBJECT = 4'd6,
        KIND_END    = 4'd7,
        KIND_ERROR  = 4'd8
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SKIP,
        ST_INT,
        ST_FLOAT,
        ST_SYMREF,
        ST_SYMIDX,
        ST_SYMTXT,
        ST_STRING,
        ST_RAW,
        ST_OBJECT
    } parse_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ValueW-1:0]   value;
        logic [IndexW-1:0]   index;
        logic                last;
    } result_t;

    localparam logic [CountW-1:0] LastByte32 = 3'd3;
    localparam logic [CountW-1:0] LastByte64 = 3'd7;

    function automatic logic [ByteW-1:0] tag_reset_value(input int unsigned i);
        tag_reset_value = ByteW'(i + 1);
    endfunction

endpackage

/* rtl/core/tbsd_if.sv */
// Handshake channels of the tagged byte stream decoder: byte input and result output.
// Depends on tbsd_pkg.
interface tbsd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [tbsd_pkg::ByteW-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface tbsd_result_if;
    logic                        valid;
    logic                        ready;
    logic [tbsd_pkg::KindW-1:0]  kind;
    logic [tbsd_pkg::ValueW-1:0] value;
    logic [tbsd_pkg::IndexW-1:0] index;
    logic                        last;

    modport source (output valid, output kind, output value, output index, output last,
                    input ready);
    modport sink   (input valid, input kind, input value, input index, input last,
                    output ready);
endinterface

/* rtl/core/tagged_byte_stream_decoder_unit.sv */
// Tagged byte stream decoder, top level. A result is registered in the output stage
// after the transaction of the byte that completes it. Throughput: one byte per cycle; the
// parser is one state step per byte and the result register plus a skid entry keep
// input ready high until two results wait. Reset (rst_n low, asynchronous) returns the
// parser to idle, clears the output stage and loads tag registers with 1 through 8.
module tagged_byte_stream_decoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tbsd_pkg::TagIdxW-1:0] cfg_index,
    input  logic [tbsd_pkg::ByteW-1:0]   cfg_data,
    tbsd_byte_if.sink                    stream,
    tbsd_result_if.source                result
);

    tbsd_pkg::tag_array_t tags;
    tbsd_pkg::result_t    push_data;
    tbsd_pkg::result_t    out_data;
    logic                 push;
    logic                 can_accept;
    logic                 accept;

    assign stream.ready = can_accept;
    assign accept       = stream.valid & can_accept;

    tbsd_tag_regs u_tag_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tags      (tags)
    );

    tbsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (stream.byte_in),
        .tags    (tags),
        .push    (push),
        .result  (push_data)
    );

    tbsd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .can_accept (can_accept),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (out_data)
    );

    assign result.kind  = out_data.kind;
    assign result.value = out_data.value;
    assign result.index = out_data.index;
    assign result.last  = out_data.last;

endmodule

/* rtl/core/tbsd_tag_regs.sv */
// Tag byte registers written through the plain configuration port.
// Depends on tbsd_pkg.
module tbsd_tag_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tbsd_pkg::TagIdxW-1:0] cfg_index,
    input  logic [tbsd_pkg::ByteW-1:0]   cfg_data,
    output tbsd_pkg::tag_array_t         tags
);

    tbsd_pkg::tag_array_t tags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tbsd_pkg::NumTags; i++)
            begin
                tags_reg[i] <= tbsd_pkg::tag_reset_value(i);
            end
        end
        else if (cfg_we)
        begin
            tags_reg[cfg_index] <= cfg_data;
        end
    end

    assign tags = tags_reg;

endmodule

/* rtl/core/tbsd_parser.sv */
// Parser state, big-endian assembly register and held symbol index; one byte per
// transaction, at most one result. Depends on tbsd_pkg.
module tbsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [tbsd_pkg::ByteW-1:0] byte_in,
    input  tbsd_pkg::tag_array_t       tags,
    output logic                       push,
    output tbsd_pkg::result_t          result
);

    tbsd_pkg::parse_state_t              phase_reg, phase_next;
    logic [tbsd_pkg::CountW-1:0]         count_reg, count_next;
    logic [tbsd_pkg::ValueW-1:0]         asm_reg, asm_next;
    logic [tbsd_pkg::IndexW-1:0]         held_reg, held_next;
    logic [tbsd_pkg::ValueW-1:0]         shifted;
    logic                                res_valid;
    tbsd_pkg::result_t                   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tbsd_pkg::ST_IDLE;
            count_reg <= '0;
            asm_reg   <= '0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            asm_reg   <= asm_next;
            held_reg  <= held_next;
        end
    end

    assign shifted = {asm_reg[tbsd_pkg::ValueW-tbsd_pkg::ByteW-1:0], byte_in};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg + 1'b1;
        asm_next   = asm_reg;
        held_next  = held_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (phase_reg)
            tbsd_pkg::ST_SKIP:
            begin
                if (byte_in == tags[tbsd_pkg::TAG_END])
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                end
            end
            tbsd_pkg::ST_INT:
            begin
                asm_next = shifted;
                if (count_reg == tbsd_pkg::LastByte32)
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_INT;
                    res.value  = {{(tbsd_pkg::ValueW-tbsd_pkg::IndexW){1'b0}},
                                  shifted[tbsd_pkg::IndexW-1:0]};
                end
            end
            tbsd_pkg::ST_FLOAT:
            begin
                asm_next = shifted;
                if (count_reg == tbsd_pkg::LastByte64)
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_FLOAT;
                    res.value  = shifted;
                end
            end
            tbsd_pkg::ST_SYMREF:
            begin
                asm_next = shifted;
                if (count_reg == tbsd_pkg::LastByte32)
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_SYMREF;
                    res.index  = shifted[tbsd_pkg::IndexW-1:0];
                end
            end
            tbsd_pkg::ST_SYMIDX:
            begin
                asm_next = shifted;
                if (count_reg == tbsd_pkg::LastByte32)
                begin
                    phase_next = tbsd_pkg::ST_SYMTXT;
                    held_next  = shifted[tbsd_pkg::IndexW-1:0];
                end
            end
            tbsd_pkg::ST_OBJECT:
            begin
                asm_next = shifted;
                if (count_reg == tbsd_pkg::LastByte32)
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_OBJECT;
                    res.index  = shifted[tbsd_pkg::IndexW-1:0];
                end
            end
            tbsd_pkg::ST_SYMTXT, tbsd_pkg::ST_STRING, tbsd_pkg::ST_RAW:
            begin
                res_valid = 1'b1;
                if (phase_reg == tbsd_pkg::ST_SYMTXT)
                begin
                    res.kind  = tbsd_pkg::KIND_SYMDEF;
                    res.index = held_reg;
                end
                else if (phase_reg == tbsd_pkg::ST_STRING)
                begin
                    res.kind = tbsd_pkg::KIND_STRING;
                end
                else
                begin
                    res.kind = tbsd_pkg::KIND_RAW;
                end
                if (byte_in == '0)
                begin
                    phase_next = tbsd_pkg::ST_IDLE;
                    res.last   = 1'b1;
                end
                else
                begin
                    res.value = {{(tbsd_pkg::ValueW-tbsd_pkg::ByteW){1'b0}}, byte_in};
                end
            end
            default:
            begin
                // idle: first matching tag register wins
                count_next = '0;
                asm_next   = '0;
                if (byte_in == tags[tbsd_pkg::TAG_INT])
                begin
                    phase_next = tbsd_pkg::ST_INT;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_FLOAT])
                begin
                    phase_next = tbsd_pkg::ST_FLOAT;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_SYMBOL_REF])
                begin
                    phase_next = tbsd_pkg::ST_SYMREF;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_SYMBOL_DEF])
                begin
                    phase_next = tbsd_pkg::ST_SYMIDX;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_STRING])
                begin
                    phase_next = tbsd_pkg::ST_STRING;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_RAW_STRING])
                begin
                    phase_next = tbsd_pkg::ST_RAW;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_OBJECT])
                begin
                    phase_next = tbsd_pkg::ST_OBJECT;
                end
                else if (byte_in == tags[tbsd_pkg::TAG_END])
                begin
                    asm_next   = asm_reg;
                    phase_next = tbsd_pkg::ST_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_END;
                end
                else
                begin
                    asm_next   = asm_reg;
                    phase_next = tbsd_pkg::ST_SKIP;
                    res_valid  = 1'b1;
                    res.kind   = tbsd_pkg::KIND_ERROR;
                    res.value  = {{(tbsd_pkg::ValueW-tbsd_pkg::ByteW){1'b0}}, byte_in};
                end
            end
        endcase
    end

    assign push   = accept & res_valid;
    assign result = res;

endmodule

/* rtl/core/tbsd_out_stage.sv */
// Result register with one skid entry; input ready holds while the skid is empty.
// Depends on tbsd_pkg.
module tbsd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbsd_pkg::result_t push_data,
    output logic              can_accept,
    output logic              out_valid,
    input  logic              out_ready,
    output tbsd_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    tbsd_pkg::result_t out_data_reg;
    tbsd_pkg::result_t skid_data_reg;
    logic              out_fire;

    assign out_fire = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign can_accept = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

/* verif/tb_tagged_byte_stream_decoder_unit.sv */
// Testbench for tagged_byte_stream_decoder_unit: drives tagged byte messages under random
// idling, predicts each decoded token and checks it field by field at the result channel.
// Depends on tbsd_pkg, tbsd_if.sv and the decoder RTL.
module tb_tagged_byte_stream_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 500_000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [tbsd_pkg::TagIdxW-1:0] cfg_index;
    logic [tbsd_pkg::ByteW-1:0] cfg_data;

    tbsd_byte_if   byte_ch ();
    tbsd_result_if result_ch ();

    tagged_byte_stream_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (byte_ch),
        .result    (result_ch)
    );

    // decoder mirror
    tbsd_pkg::tag_array_t     tag_regs;
    tbsd_pkg::parse_state_t   dec_state;
    logic [2:0]               dec_count;
    logic [63:0]              dec_bits;
    logic [31:0]              dec_held_index;
    tbsd_pkg::result_t        pending_tokens[$];

    int unsigned    fail_count = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    cycle_count = 0;
    int unsigned    sink_wait = 0;
    bit             src_quiet = 1'b0;
    bit             sink_quiet = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void push_token(tbsd_pkg::kind_t k, logic [63:0] v, logic [31:0] idx,
                                       logic l);
        pending_tokens.push_back('{kind: k, value: v, index: idx, last: l});
    endfunction

    function automatic void text_char(tbsd_pkg::kind_t k, logic [7:0] b, logic [31:0] idx);
        if (b == 8'h00)
        begin
            push_token(k, '0, idx, 1'b1);
            dec_state = tbsd_pkg::ST_IDLE;
        end
        else
            push_token(k, 64'(b), idx, 1'b0);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        tbsd_pkg::parse_state_t s;
        bit hit;
        s = dec_state;
        hit = 1'b0;
        case (s)
            tbsd_pkg::ST_SKIP:
                if (b == tag_regs[tbsd_pkg::TAG_END])
                    dec_state = tbsd_pkg::ST_IDLE;
            tbsd_pkg::ST_INT, tbsd_pkg::ST_FLOAT, tbsd_pkg::ST_SYMREF, tbsd_pkg::ST_SYMIDX,
            tbsd_pkg::ST_OBJECT:
            begin
                dec_bits = {dec_bits[55:0], b};
                if (dec_count != ((s == tbsd_pkg::ST_FLOAT) ? tbsd_pkg::LastByte64
                                                              : tbsd_pkg::LastByte32))
                    dec_count++;
                else
                begin
                    dec_count = '0;
                    dec_state = tbsd_pkg::ST_IDLE;
                    case (s)
                        tbsd_pkg::ST_INT:
                            push_token(tbsd_pkg::KIND_INT, {32'h0, dec_bits[31:0]}, '0, 1'b0);
                        tbsd_pkg::ST_FLOAT:
                            push_token(tbsd_pkg::KIND_FLOAT, dec_bits, '0, 1'b0);
                        tbsd_pkg::ST_SYMREF:
                            push_token(tbsd_pkg::KIND_SYMREF, '0, dec_bits[31:0], 1'b0);
                        tbsd_pkg::ST_OBJECT:
                            push_token(tbsd_pkg::KIND_OBJECT, '0, dec_bits[31:0], 1'b0);
                        default:
                        begin
                            dec_held_index = dec_bits[31:0];
                            dec_state = tbsd_pkg::ST_SYMTXT;
                        end
                    endcase
                end
            end
            tbsd_pkg::ST_SYMTXT: text_char(tbsd_pkg::KIND_SYMDEF, b, dec_held_index);
            tbsd_pkg::ST_STRING: text_char(tbsd_pkg::KIND_STRING, b, '0);
            tbsd_pkg::ST_RAW:    text_char(tbsd_pkg::KIND_RAW, b, '0);
            default:
            begin
                dec_state = tbsd_pkg::ST_IDLE;
                dec_bits = '0;
                dec_count = '0;
                // first matching register wins
                for (int i = 0; i < tbsd_pkg::NumTags - 1; i++)
                begin
                    if (!hit && b == tag_regs[i])
                    begin
                        hit = 1'b1;
                        case (tbsd_pkg::tag_sel_t'(i))
                            tbsd_pkg::TAG_INT:        dec_state = tbsd_pkg::ST_INT;
                            tbsd_pkg::TAG_FLOAT:      dec_state = tbsd_pkg::ST_FLOAT;
                            tbsd_pkg::TAG_SYMBOL_REF: dec_state = tbsd_pkg::ST_SYMREF;
                            tbsd_pkg::TAG_SYMBOL_DEF: dec_state = tbsd_pkg::ST_SYMIDX;
                            tbsd_pkg::TAG_STRING:     dec_state = tbsd_pkg::ST_STRING;
                            tbsd_pkg::TAG_RAW_STRING: dec_state = tbsd_pkg::ST_RAW;
                            default:                  dec_state = tbsd_pkg::ST_OBJECT;
                        endcase
                    end
                end
                if (!hit)
                begin
                    if (b == tag_regs[tbsd_pkg::TAG_END])
                        push_token(tbsd_pkg::KIND_END, '0, '0, 1'b0);
                    else
                    begin
                        dec_state = tbsd_pkg::ST_SKIP;
                        push_token(tbsd_pkg::KIND_ERROR, 64'(b), '0, 1'b0);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            decode_byte(byte_ch.byte_in);
    end

    always @(posedge clk)
    begin
        tbsd_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $display({"%0t ns: unexpected token, expected none, ",
                          "actual kind %0d value %h index %h last %b"},
                         $time, result_ch.kind, result_ch.value, result_ch.index, result_ch.last);
                fail_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("kind", 64'(want.kind), 64'(result_ch.kind));
                check_field("value", want.value, result_ch.value);
                check_field("index", 64'(want.index), 64'(result_ch.index));
                check_field("last", 64'(want.last), 64'(result_ch.last));
            end
        end
    end

    // result sink: a fresh random stall, possibly none, after every transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (result_ch.ready && result_ch.valid)
        begin
            sink_wait = sink_quiet ? 0 : $urandom_range(0, 12);
            result_ch.ready <= (sink_wait == 0);
        end
        else if (!result_ch.ready)
        begin
            if (sink_wait > 0)
                sink_wait--;
            result_ch.ready <= (sink_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("[tagged_byte_stream_decoder_unit] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_tags(input tbsd_pkg::tag_array_t vals);
        for (int i = 0; i < tbsd_pkg::NumTags; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= tbsd_pkg::tag_sel_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            tag_regs[i] = vals[i];
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_unknown_tag();
        logic [7:0] b;
        bit hit;
        do
        begin
            b = 8'($urandom_range(0, 255));
            hit = 1'b0;
            for (int i = 0; i < tbsd_pkg::NumTags; i++)
                if (tag_regs[i] == b)
                    hit = 1'b1;
        end
        while (hit);
        return b;
    endfunction

    task automatic send_field(input tbsd_pkg::tag_sel_t sel, input logic [63:0] num,
                              input int unsigned text_len);
        send_byte(tag_regs[sel]);
        case (sel)
            tbsd_pkg::TAG_FLOAT:
                for (int i = 7; i >= 0; i--)
                    send_byte(num[8*i +: 8]);
            tbsd_pkg::TAG_INT, tbsd_pkg::TAG_SYMBOL_REF, tbsd_pkg::TAG_SYMBOL_DEF,
            tbsd_pkg::TAG_OBJECT:
                for (int i = 3; i >= 0; i--)
                    send_byte(num[8*i +: 8]);
            default: ;
        endcase
        if (sel inside {tbsd_pkg::TAG_SYMBOL_DEF, tbsd_pkg::TAG_STRING,
                        tbsd_pkg::TAG_RAW_STRING})
        begin
            repeat (text_len) send_byte(8'($urandom_range(1, 255)));
            send_byte(8'h00);
        end
    endtask

    task automatic send_error_run(input logic [7:0] bad, input int unsigned junk);
        send_byte(bad);
        repeat (junk) send_byte(8'($urandom_range(0, 255)));
        send_byte(tag_regs[tbsd_pkg::TAG_END]);
    endtask

    task automatic send_random_message();
        int unsigned n_fields;
        int unsigned pick;
        logic [63:0] num;
        int unsigned len;
        n_fields = $urandom_range(1, 4);
        repeat (n_fields)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       num = '0;
                1:       num = '1;
                default: num = {$urandom, $urandom};
            endcase
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
            if (pick < 82)
                send_field(tbsd_pkg::tag_sel_t'($urandom_range(0, 6)), num, len);
            else if (pick < 91)
                send_error_run(pick_unknown_tag(), $urandom_range(0, 5));
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        send_field(tbsd_pkg::TAG_END, '0, 0);
    endtask

    task automatic test_directed_defaults();
        send_field(tbsd_pkg::TAG_INT, 64'hFFFF_FFFF, 0);
        send_field(tbsd_pkg::TAG_FLOAT, 64'h80FF_00FF_0000_FF01, 0);
        send_field(tbsd_pkg::TAG_SYMBOL_REF, 64'h0, 0);
        send_field(tbsd_pkg::TAG_SYMBOL_DEF, 64'h1234_5678, 0);
        send_field(tbsd_pkg::TAG_STRING, 64'h0, 0);
        send_field(tbsd_pkg::TAG_RAW_STRING, 64'h0, 1);
        send_field(tbsd_pkg::TAG_OBJECT, 64'hFFFF_FFFF, 0);
        send_field(tbsd_pkg::TAG_END, 64'h0, 0);
        // unknown tag, an int tag that must be skipped, then end of message
        send_byte(8'hFF);
        send_byte(tag_regs[tbsd_pkg::TAG_INT]);
        send_byte(tag_regs[tbsd_pkg::TAG_END]);
    endtask

    task automatic test_tag_extremes();
        drain_results();
        program_tags({8'hAA, 8'h55, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'h00});
        for (int i = 0; i < tbsd_pkg::NumTags; i++)
            send_field(tbsd_pkg::tag_sel_t'(i), {$urandom, $urandom}, $urandom_range(0, 3));
        send_error_run(pick_unknown_tag(), 2);
        repeat (3) send_random_message();
    endtask

    task automatic test_shadowed_tags();
        drain_results();
        // int/float, ref/def, string/raw, object/end share codes
        program_tags({8'h43, 8'h43, 8'h32, 8'h32, 8'h21, 8'h21, 8'h10, 8'h10});
        for (int i = 0; i < tbsd_pkg::NumTags; i++)
            send_field(tbsd_pkg::tag_sel_t'(i), {$urandom, $urandom}, $urandom_range(0, 3));
        send_error_run(pick_unknown_tag(), 3);
        repeat (2) send_random_message();
    endtask

    task automatic test_random_traffic(input int unsigned n_configs,
                                       input int unsigned bytes_each);
        tbsd_pkg::tag_array_t tags;
        logic [7:0] b;
        bit dup;
        bit paused;
        int unsigned stop_at;
        repeat (n_configs)
        begin
            drain_results();
            for (int i = 0; i < tbsd_pkg::NumTags; i++)
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    dup = 1'b0;
                    for (int j = 0; j < i; j++)
                        if (tags[j] == b)
                            dup = 1'b1;
                end
                while (dup);
                tags[i] = b;
            end
            program_tags(tags);
            stop_at = bytes_sent + bytes_each;
            paused = 1'b0;
            while (bytes_sent < stop_at)
            begin
                if ($urandom_range(0, 7) == 0)
                    src_quiet = !src_quiet;
                if ($urandom_range(0, 7) == 0)
                    sink_quiet = !sink_quiet;
                if (!paused && bytes_sent + bytes_each / 2 > stop_at)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                send_random_message();
            end
        end
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tbsd_pkg::TAG_INT;
        cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.byte_in = '0;
        for (int i = 0; i < tbsd_pkg::NumTags; i++)
            tag_regs[i] = 8'(i + 1);
        dec_state = tbsd_pkg::ST_IDLE;
        dec_count = '0;
        dec_bits = '0;
        dec_held_index = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_tag_extremes();
        test_shadowed_tags();
        test_random_traffic(3, 220);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[tagged_byte_stream_decoder_unit] OK");
        else
            $display("[tagged_byte_stream_decoder_unit] ERROR");
        $finish;
    end

endmodule
